### rtl/coadc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package coadc_pkg;

    // Controller modes, also the value of the mode field of a result item.
    typedef enum logic [1:0] {
        MODE_SELFTEST  = 2'd0,
        MODE_NORMAL    = 2'd1,
        MODE_OPEN      = 2'd2,
        MODE_EMERGENCY = 2'd3
    } t_mode;

    // Input item kinds, carried on tuser.
    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_BUTTON = 2'd1,
        OP_ALARM  = 2'd2,
        OP_STOP   = 2'd3
    } t_opcode;

    // Telemetry codes.
    typedef enum logic [1:0] {
        TEL_NONE      = 2'd0,
        TEL_NORMAL    = 2'd1,
        TEL_OPEN      = 2'd2,
        TEL_EMERGENCY = 2'd3
    } t_tel_code;

    // Configuration register indexes.
    localparam logic CFG_SELFTEST_TIME = 1'b0;
    localparam logic CFG_DOOR_HOLD     = 1'b1;

    localparam int unsigned CFG_W      = 20;
    localparam int unsigned CO_W       = 16;
    localparam int unsigned IN_DATA_W  = 32;
    localparam int unsigned OUT_DATA_W = 48;

    localparam logic [CFG_W-1:0] SELFTEST_TIME_RST = 20'd3000;
    localparam logic [CFG_W-1:0] DOOR_HOLD_RST     = 20'd5000;

    // Door angle commanded while the door command bit is set, in degrees.
    localparam int unsigned DOOR_OPEN_ANGLE = 90;

endpackage

`default_nettype wire

### rtl/co_alarm_door_controller.sv
`timescale 1ns / 1ps
`default_nettype none

// The result item of an accepted input item is registered and shown on the master side in the cycle after acceptance.
// Throughput: one item per cycle; the input is stalled only while the result register
// holds an item that the downstream side has not taken.
// Reset (synchronous, active low): self-test mode, timer and alert flag cleared,
// registers back to 3000 ms and 5000 ms, no result pending.
module co_alarm_door_controller #(
    parameter int unsigned TIMER_BITS = 20
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    // Configuration write port
    input  wire                               i_cfg_we,
    input  wire                               i_cfg_addr,
    input  wire  [coadc_pkg::CFG_W-1:0]       i_cfg_wdata,
    // Input stream
    input  wire                               s_tvalid,
    output logic                              s_tready,
    // tdata: event_co [15:0], sensor_co [31:16]
    input  wire  [coadc_pkg::IN_DATA_W-1:0]   s_tdata,
    // tuser: opcode [1:0]
    input  wire  [1:0]                        s_tuser,
    // Output stream
    output logic                              m_tvalid,
    input  wire                               m_tready,
    // tdata: mode [1:0], green_led [2], red_led [3], door_cmd [4], buzzer_on [5],
    // telemetry_code [7:6], telemetry_co [23:8], webhook_fire [24], record_co [25],
    // recorded_co [41:26], zero [47:42]
    output logic [coadc_pkg::OUT_DATA_W-1:0]  m_tdata
);
    import coadc_pkg::*;

    // Compare width covers both the timer and the limit registers.
    localparam int unsigned CMP_W = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
    localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

    // Configuration and controller state
    logic [CFG_W-1:0]      r_selftest_time;
    logic [CFG_W-1:0]      r_door_hold;
    t_mode                 r_mode,     n_mode;
    logic [TIMER_BITS-1:0] r_elapsed,  n_elapsed;
    logic                  r_hook_sent, n_hook_sent;

    // Result register
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data, n_out_data;

    logic                  in_acc;
    t_opcode               op;
    logic [CO_W-1:0]       event_co;
    logic [CO_W-1:0]       sensor_co;
    logic [TIMER_BITS-1:0] elapsed_inc;
    logic [CFG_W-1:0]      limit;
    t_tel_code             tcode;
    logic                  hook;
    logic                  rec;
    logic [CO_W-1:0]       rec_val;
    logic [CO_W-1:0]       tel_co;
    logic                  green, red, door, buzz;

    assign op        = t_opcode'(s_tuser);
    assign event_co  = s_tdata[CO_W-1:0];
    assign sensor_co = s_tdata[2*CO_W-1:CO_W];

    // The result register frees up in the same cycle as it is taken.
    assign s_tready = !r_out_valid || m_tready;
    assign in_acc   = s_tvalid && s_tready;

    // Next mode, timer and pulses for the item at the input.
    always_comb begin
        n_mode      = r_mode;
        n_elapsed   = r_elapsed;
        n_hook_sent = r_hook_sent;
        tcode       = TEL_NONE;
        hook        = 1'b0;
        rec         = 1'b0;
        rec_val     = '0;
        elapsed_inc = (r_elapsed != TIMER_MAX) ? r_elapsed + 1'b1 : r_elapsed;
        limit       = (r_mode == MODE_SELFTEST) ? r_selftest_time : r_door_hold;

        case (op)
            OP_TICK: begin
                if (r_mode == MODE_SELFTEST || r_mode == MODE_OPEN) begin
                    n_elapsed = elapsed_inc;
                    if (CMP_W'(elapsed_inc) >= CMP_W'(limit)) begin
                        n_mode = MODE_NORMAL;
                    end
                end
            end
            OP_ALARM: begin
                if (r_mode != MODE_SELFTEST) begin
                    rec     = 1'b1;
                    rec_val = event_co;
                end
                n_mode = MODE_EMERGENCY;
            end
            OP_BUTTON: begin
                if (r_mode == MODE_NORMAL) begin
                    n_mode = MODE_OPEN;
                end
            end
            default: begin
                if (r_mode == MODE_EMERGENCY) begin
                    n_mode = MODE_NORMAL;
                end
            end
        endcase

        // Any non-tick event while open restarts the door count.
        if (op != OP_TICK && n_mode == MODE_OPEN) begin
            n_elapsed = '0;
        end

        // Mode change: clear the timer, report it, fire the alert once.
        if (n_mode != r_mode) begin
            n_elapsed = '0;
            unique case (n_mode)
                MODE_NORMAL: begin
                    tcode       = TEL_NORMAL;
                    n_hook_sent = 1'b0;
                end
                MODE_OPEN: begin
                    tcode = TEL_OPEN;
                end
                MODE_EMERGENCY: begin
                    tcode = TEL_EMERGENCY;
                    if (!r_hook_sent) begin
                        hook        = 1'b1;
                        n_hook_sent = 1'b1;
                    end
                end
                default: begin
                    tcode = TEL_NONE;
                end
            endcase
        end

        tel_co = (tcode != TEL_NONE) ? sensor_co : '0;
        green  = (n_mode != MODE_EMERGENCY);
        red    = (n_mode == MODE_SELFTEST) || (n_mode == MODE_EMERGENCY);
        door   = (n_mode != MODE_NORMAL);
        buzz   = red;

        n_out_data = {6'd0, rec_val, rec, hook, tel_co, tcode, buzz, door, red, green, n_mode};
    end

    // Configuration registers; index is fully decoded by its single bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_selftest_time <= SELFTEST_TIME_RST;
            r_door_hold     <= DOOR_HOLD_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_SELFTEST_TIME: r_selftest_time <= i_cfg_wdata;
                CFG_DOOR_HOLD:     r_door_hold     <= i_cfg_wdata;
                default:           r_door_hold     <= r_door_hold;
            endcase
        end
    end

    // Controller state and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_SELFTEST;
            r_elapsed   <= '0;
            r_hook_sent <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_mode      <= n_mode;
                r_elapsed   <= n_elapsed;
                r_hook_sent <= n_hook_sent;
                r_out_valid <= 1'b1;
            end else if (m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_out_data <= n_out_data;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out_data;

    // The alert flag is always set while in emergency.
    a_hook_in_emerg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_EMERGENCY) |-> r_hook_sent)
        else $error("alert flag clear in emergency");

    // The timer only runs in self-test and open.
    a_timer_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_NORMAL || r_mode == MODE_EMERGENCY) |-> (r_elapsed == '0))
        else $error("timer running in normal or emergency");

    // A webhook pulse goes out only with the emergency telemetry code.
    a_hook_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data[24]) |->
        (r_out_data[7:6] == TEL_EMERGENCY && r_out_data[1:0] == MODE_EMERGENCY))
        else $error("webhook pulse without entry into emergency");

    // The mode reported in a fresh result matches the stored mode.
    a_mode_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(in_acc) && $past(i_rst_n) |-> (r_out_data[1:0] == r_mode))
        else $error("result mode differs from controller mode");

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import coadc_pkg::*;

    localparam int TIMER_W     = 20;
    localparam int N_PHASES    = 8;
    localparam int PHASE_ITEMS = 234;
    localparam int MAX_CYCLES  = 400000;
    localparam int HOLD_AT     = 300;
    localparam int HOLD_CYCLES = 64;

    // One input item and the status word it should produce.
    typedef struct {
        t_opcode     op;
        logic [15:0] event_co;
        logic [15:0] sensor_co;
    } t_door_item;

    typedef struct {
        t_mode       mode;
        logic        green;
        logic        red;
        logic        door;
        logic        buzz;
        t_tel_code   tel;
        logic [15:0] tel_co;
        logic        hook;
        logic        rec;
        logic [15:0] rec_co;
    } t_door_status;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic                   i_cfg_addr = 1'b0;
    logic [CFG_W-1:0]       i_cfg_wdata = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata = '0;
    logic [1:0]             s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_tdata;

    // Items waiting to be offered, and status words still to arrive.
    t_door_item   pend_q[$];
    t_door_status status_q[$];

    // Predicted controller state and register copies.
    t_mode              ctl_mode = MODE_SELFTEST;
    logic [TIMER_W-1:0] ctl_elapsed = '0;
    logic               hook_sent = 1'b0;
    logic [CFG_W-1:0]   cfg_selftest_ms = SELFTEST_TIME_RST;
    logic [CFG_W-1:0]   cfg_door_hold_ms = DOOR_HOLD_RST;

    int idle_pct = 15;
    int n_errors = 0;
    int n_checked = 0;

    co_alarm_door_controller #(
        .TIMER_BITS (TIMER_W)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Advance the predicted controller by one item and return its status word.
    function automatic t_door_status step_controller(t_door_item it);
        t_door_status     r;
        t_mode            prev;
        t_mode            nxt;
        logic [CFG_W-1:0] limit;
        prev     = ctl_mode;
        nxt      = prev;
        r.tel    = TEL_NONE;
        r.hook   = 1'b0;
        r.rec    = 1'b0;
        r.rec_co = '0;
        if (it.op == OP_TICK) begin
            // Only self-test and open count time; the compare follows the increment.
            if (prev == MODE_SELFTEST || prev == MODE_OPEN) begin
                limit = (prev == MODE_SELFTEST) ? cfg_selftest_ms : cfg_door_hold_ms;
                if (ctl_elapsed != '1) ctl_elapsed = ctl_elapsed + 1'b1;
                if (ctl_elapsed >= limit) nxt = MODE_NORMAL;
            end
        end else begin
            case (it.op)
                OP_ALARM: begin
                    // An alarm during self-test is not recorded.
                    if (prev != MODE_SELFTEST) begin
                        r.rec    = 1'b1;
                        r.rec_co = it.event_co;
                    end
                    nxt = MODE_EMERGENCY;
                end
                OP_BUTTON: if (prev == MODE_NORMAL) nxt = MODE_OPEN;
                OP_STOP:   if (prev == MODE_EMERGENCY) nxt = MODE_NORMAL;
                default: ;
            endcase
            // Any non-tick event while the door is open restarts the door count.
            if (nxt == MODE_OPEN) ctl_elapsed = '0;
        end
        if (nxt != prev) begin
            ctl_elapsed = '0;
            case (nxt)
                MODE_NORMAL: begin
                    r.tel     = TEL_NORMAL;
                    hook_sent = 1'b0;
                end
                MODE_OPEN: r.tel = TEL_OPEN;
                MODE_EMERGENCY: begin
                    r.tel = TEL_EMERGENCY;
                    if (!hook_sent) begin
                        r.hook    = 1'b1;
                        hook_sent = 1'b1;
                    end
                end
                default: ;
            endcase
        end
        ctl_mode = nxt;
        r.mode   = nxt;
        r.green  = (nxt != MODE_EMERGENCY);
        r.red    = (nxt == MODE_SELFTEST || nxt == MODE_EMERGENCY);
        r.door   = (nxt != MODE_NORMAL);
        r.buzz   = r.red;
        r.tel_co = (r.tel != TEL_NONE) ? it.sensor_co : '0;
        return r;
    endfunction

    // Sender: offers queued items, with random gaps between them.
    t_door_item cur_item;
    int         send_gap = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                status_q.push_back(step_controller(cur_item));
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap = send_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (pend_q.size() > 0) begin
                    cur_item = pend_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {cur_item.sensor_co, cur_item.event_co};
                    s_tuser  <= cur_item.op;
                    if ($urandom_range(0, 99) < idle_pct) send_gap = $urandom_range(1, 12);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic report_diff(string field, longint unsigned want, longint unsigned got);
        if (want != got) begin
            $error("%s: expected %0h, got %0h", field, want, got);
            n_errors = n_errors + 1;
        end
    endtask

    // Receiver: stalls in random bursts, once for a long stretch, and checks
    // every accepted item against the oldest prediction.
    int hold_left = 0;
    bit hold_done = 1'b0;

    always @(posedge i_clk) begin
        t_door_status want;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                n_checked = n_checked + 1;
                if (status_q.size() == 0) begin
                    $error("unexpected status item %0h", m_tdata);
                    n_errors = n_errors + 1;
                end else begin
                    want = status_q.pop_front();
                    report_diff("mode", want.mode, m_tdata[1:0]);
                    report_diff("green_led", want.green, m_tdata[2]);
                    report_diff("red_led", want.red, m_tdata[3]);
                    report_diff("door_cmd", want.door, m_tdata[4]);
                    report_diff("buzzer_on", want.buzz, m_tdata[5]);
                    report_diff("telemetry_code", want.tel, m_tdata[7:6]);
                    report_diff("telemetry_co", want.tel_co, m_tdata[23:8]);
                    report_diff("webhook_fire", want.hook, m_tdata[24]);
                    report_diff("record_co", want.rec, m_tdata[25]);
                    report_diff("recorded_co", want.rec_co, m_tdata[41:26]);
                    report_diff("padding", 0, m_tdata[47:42]);
                end
            end
            if (!hold_done && n_checked >= HOLD_AT) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end else if (hold_left == 0 && $urandom_range(0, 99) < idle_pct) begin
                hold_left = $urandom_range(1, 12);
            end
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog.
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < MAX_CYCLES) begin
            @(posedge i_clk);
            cycles = cycles + 1;
        end
        $display("tb_top: done, errors");
        $finish;
    end

    function automatic logic [15:0] rand_co();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic push_item(t_opcode op, logic [15:0] ev, logic [15:0] sn);
        t_door_item it;
        it.op        = op;
        it.event_co  = ev;
        it.sensor_co = sn;
        pend_q.push_back(it);
    endtask

    // Runs of up to run_max ticks, which can reach a short door timeout, mixed with events.
    task automatic queue_random(int n, int run_max);
        int left;
        int len;
        int r;
        left = n;
        while (left > 0) begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
                len = $urandom_range(1, run_max);
                if (len > left) len = left;
                repeat (len) push_item(OP_TICK, rand_co(), rand_co());
                left = left - len;
            end else begin
                push_item(r < 70 ? OP_BUTTON : r < 82 ? OP_ALARM : r < 94 ? OP_STOP : OP_TICK,
                          rand_co(), rand_co());
                left = left - 1;
            end
        end
    endtask

    // Returns once every queued item has gone in and every status word has come out.
    task automatic wait_drained();
        do @(posedge i_clk);
        while (pend_q.size() != 0 || s_tvalid || status_q.size() != 0);
    endtask

    task automatic write_reg(logic addr, logic [CFG_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= value;
        if (addr == CFG_SELFTEST_TIME) cfg_selftest_ms = value;
        else cfg_door_hold_ms = value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Main sequence: directed items, then phases of random items under varied settings.
    initial begin : main_seq
        logic [CFG_W-1:0] door_ms;
        logic [CFG_W-1:0] test_ms;
        int               run_max;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Self-test ignores buttons and stops; the count keeps going.
        push_item(OP_TICK, 16'h0000, 16'h0000);
        push_item(OP_TICK, 16'hFFFF, 16'hFFFF);
        push_item(OP_BUTTON, 16'hFFFF, 16'hFFFF);
        push_item(OP_STOP, 16'h0000, 16'hFFFF);
        push_item(OP_TICK, 16'h5A5A, 16'hA5A5);
        wait_drained();
        // Lowering the limit below the count only fires on the next tick.
        write_reg(CFG_SELFTEST_TIME, 20'd2);
        if ($urandom_range(0, 1) == 0) begin
            push_item(OP_TICK, 16'h1234, 16'hFFFF);
        end else begin
            // An alarm in self-test goes to emergency but is not recorded.
            push_item(OP_ALARM, 16'hFFFF, 16'h8001);
            push_item(OP_STOP, 16'h0000, 16'h7FFE);
        end
        push_item(OP_TICK, 16'hFFFF, 16'h0000);
        push_item(OP_STOP, 16'hFFFF, 16'hFFFF);
        push_item(OP_BUTTON, 16'h0000, 16'hFFFF);
        push_item(OP_TICK, 16'h0001, 16'h0002);
        push_item(OP_TICK, 16'h0003, 16'h0004);
        push_item(OP_BUTTON, 16'hFFFF, 16'h0000);
        push_item(OP_STOP, 16'h0000, 16'h0000);
        push_item(OP_TICK, 16'h0000, 16'h0000);
        push_item(OP_ALARM, 16'hFFFF, 16'h0000);
        push_item(OP_ALARM, 16'h0000, 16'hFFFF);
        push_item(OP_TICK, 16'hFFFF, 16'hFFFF);
        push_item(OP_BUTTON, 16'hFFFF, 16'hFFFF);
        push_item(OP_STOP, 16'hC3C3, 16'h3C3C);
        push_item(OP_ALARM, 16'h8000, 16'h0001);
        push_item(OP_STOP, 16'h0001, 16'h8000);
        push_item(OP_BUTTON, 16'h0000, 16'hFFFF);
        wait_drained();

        for (int p = 0; p < N_PHASES; p++) begin
            case (p)
                0:       door_ms = 20'd0;
                1:       door_ms = 20'd1;
                2:       door_ms = 20'hFFFFF;
                default: door_ms = 20'($urandom_range(2, 40));
            endcase
            case (p % 3)
                0:       test_ms = 20'd0;
                1:       test_ms = 20'hFFFFF;
                default: test_ms = 20'($urandom_range(1, 5000));
            endcase
            write_reg(CFG_SELFTEST_TIME, test_ms);
            write_reg(CFG_DOOR_HOLD, door_ms);
            // No idling at all in the closing phase.
            idle_pct = (p == N_PHASES - 1) ? 0 : $urandom_range(0, 30);
            run_max  = (door_ms > 20'd57) ? 60 : int'(door_ms) + 3;
            queue_random(PHASE_ITEMS, run_max);
            wait_drained();
        end

        repeat (8) @(posedge i_clk);
        if (status_q.size() != 0) begin
            $error("%0d status items never arrived", status_q.size());
            n_errors = n_errors + 1;
        end
        if (n_errors == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

### files.f
rtl/coadc_pkg.sv
rtl/co_alarm_door_controller.sv
tb/sv/tb_top.sv
